// ===== rtl/xfp_pkg.sv =====
// Shared types, constants and a helper function of the xoshiro family generator.
`timescale 1ns / 1ps
package xfp_pkg;

  typedef enum logic [1:0] {
    ALG_SS  = 2'd0,
    ALG_PP  = 2'd1,
    ALG_P   = 2'd2,
    ALG_ROX = 2'd3
  } xfp_alg_t;

  typedef enum logic {
    ACT_DRAW = 1'b0,
    ACT_LOAD = 1'b1
  } xfp_action_t;

  // Register index, taken from paddr[2].
  localparam logic REG_ALG = 1'b0;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned SH_ADV_T   = 17;
  localparam int unsigned ROT_ADV_W3 = 45;
  localparam int unsigned ROT_SS     = 7;
  localparam int unsigned ROT_PP     = 23;
  localparam int unsigned ROT_ROX_A  = 24;
  localparam int unsigned SH_ROX_B   = 16;
  localparam int unsigned ROT_ROX_B  = 37;
  localparam int unsigned SH_MUL5    = 2;
  localparam int unsigned SH_MUL9    = 3;

  // Operands of one draw, captured from the state before it advances.
  typedef struct packed {
    xfp_alg_t    alg;
    logic [63:0] a;
    logic [63:0] b;
  } xfp_op_t;

  typedef struct packed {
    logic s1_valid;
    logic out_load;
  } xfp_back_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned k);
    rotl64 = (v << k) | (v >> (64 - k));
  endfunction

endpackage

// ===== rtl/xoshiro_family_prng_unit.sv =====
// Top level of the multi-algorithm 64-bit xoshiro family generator.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_action, in_word_select, in_seed_word
//   out      output     out_valid/out_stall out_random_value
//   cfg      input      APB psel/penable    algorithm_select at byte address 0
//
// An input word is taken every cycle while the operand queue has room; the state update
// is done in the cycle it is taken. A draw reaches out_valid through the operand queue
// slot, the first scrambler stage and the result register.
// Reset clears the state words, the algorithm to xoshiro256**, and all valid flags.
// A stalled output backs up the scrambler and then the queue, which stalls the input.
`timescale 1ns / 1ps
module xoshiro_family_prng_unit
  import xfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_word_select,
  input  logic [63:0] in_seed_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_random_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  xfp_alg_t         alg_r, alg_nxt;
  logic             q_push, q_pop, q_full, q_empty;
  xfp_op_t          q_push_op, q_pop_op;
  xfp_back_status_t bk_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALG) ? {30'd0, alg_r} : 32'd0;

  always_comb begin
    alg_nxt = alg_r;
    if (psel && penable && pwrite && (paddr[2] == REG_ALG)) begin
      alg_nxt = xfp_alg_t'(pwdata[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= ALG_SS;
    end else begin
      alg_r <= alg_nxt;
    end
  end

  xfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .alg            (alg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_word_select (in_word_select),
    .in_seed_word   (in_seed_word),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_push_op      (q_push_op)
  );

  xfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .pop_op  (q_pop_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  xfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_op             (q_pop_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .status           (bk_status)
  );

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> in_stall)
    else $error("Input taken while the operand queue is full.");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !bk_status.s1_valid) |=> bk_status.s1_valid)
    else $error("Queued draw did not enter the scrambler.");

  a_output_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !bk_status.s1_valid && q_empty && !q_push) |=> !out_valid)
    else $error("Result word shown with no draw behind it.");

endmodule

// ===== rtl/xfp_front.sv =====
// Front end: takes input words, holds the generator state and queues draw operands.
`timescale 1ns / 1ps
module xfp_front
  import xfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  xfp_alg_t    alg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_word_select,
  input  logic [63:0] in_seed_word,
  input  logic        q_full,
  output logic        q_push,
  output xfp_op_t     q_push_op
);

  logic [63:0] words_r   [4];
  logic [63:0] words_nxt [4];
  logic        accept;
  logic [63:0] adv_t;
  logic [63:0] w2x;
  logic [63:0] w3x;
  logic [63:0] rox_b;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && (in_action == ACT_DRAW);

  assign q_push_op.alg = alg;
  assign q_push_op.a   = (alg == ALG_SS) ? words_r[1] : words_r[0];
  assign q_push_op.b   = (alg == ALG_ROX) ? words_r[1] : words_r[3];

  always_comb begin
    adv_t = words_r[1] << SH_ADV_T;
    w2x   = words_r[2] ^ words_r[0];
    w3x   = words_r[3] ^ words_r[1];
    rox_b = words_r[1] ^ words_r[0];
    for (int i = 0; i < 4; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (accept) begin
      if (in_action == ACT_LOAD) begin
        words_nxt[in_word_select] = in_seed_word;
      end else if (alg == ALG_ROX) begin
        words_nxt[0] = rotl64(words_r[0], ROT_ROX_A) ^ rox_b ^ (rox_b << SH_ROX_B);
        words_nxt[1] = rotl64(rox_b, ROT_ROX_B);
      end else begin
        words_nxt[0] = words_r[0] ^ w3x;
        words_nxt[1] = words_r[1] ^ w2x;
        words_nxt[2] = w2x ^ adv_t;
        words_nxt[3] = rotl64(w3x, ROT_ADV_W3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/xfp_queue.sv =====
// Short first-in first-out queue of draw operands between front and back.
`timescale 1ns / 1ps
module xfp_queue
  import xfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  xfp_op_t push_op,
  input  logic    pop,
  output xfp_op_t pop_op,
  output logic    full,
  output logic    empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  xfp_op_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/xfp_back.sv =====
// Back end: two-stage output scrambler with a registered result word.
`timescale 1ns / 1ps
module xfp_back
  import xfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  xfp_op_t          q_op,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_random_value,
  output xfp_back_status_t status
);

  logic        s1_valid_r, s1_valid_nxt;
  xfp_alg_t    s1_alg_r;
  logic [63:0] s1_x_r, s1_aux_r;
  logic [63:0] s1_x_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_load;
  logic        s1_adv;
  logic [63:0] rot_y;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_load;
  assign q_pop    = s1_adv && !q_empty;

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign status.s1_valid  = s1_valid_r;
  assign status.out_load  = out_load;

  always_comb begin
    s1_valid_nxt = s1_adv ? !q_empty : s1_valid_r;
    case (q_op.alg)
      ALG_SS:  s1_x_nxt = (q_op.a << SH_MUL5) + q_op.a;
      default: s1_x_nxt = q_op.a + q_op.b;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
    rot_y         = '0;
    case (s1_alg_r)
      ALG_SS: begin
        rot_y         = rotl64(s1_x_r, ROT_SS);
        out_value_nxt = (rot_y << SH_MUL9) + rot_y;
      end
      ALG_PP: begin
        rot_y         = rotl64(s1_x_r, ROT_PP);
        out_value_nxt = rot_y + s1_aux_r;
      end
      default: out_value_nxt = s1_x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_alg_r <= q_op.alg;
      s1_x_r   <= s1_x_nxt;
      s1_aux_r <= q_op.a;
    end
    if (out_load && s1_valid_r) begin
      out_value_r <= out_value_nxt;
    end
  end

endmodule
